// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the box blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define BB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define BB_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define BB_ASSERT(lbl, clk, rst_n, prop, msg)
`define BB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/bblur_pkg.sv =====
// Shared types and constants of the box blur block.
`default_nettype none
package bblur_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int RADIUS_DEF     = 7;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int NUM_CH    = 3;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } t_kind;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             end_of_frame;
    } t_out_word;
endpackage
`default_nettype wire

// ===== rtl/bblur_if.sv =====
// Valid/ready channel carrying one word of type T.
`default_nettype none
interface bblur_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bblur_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/box_blur_15x15_replicate.sv =====
// Top level of the streaming box blur with edge replication.
//
//  channel  | dir | word        | moves when
//  i_pix    | in  | t_in_word   | valid && ready
//  o_res    | out | t_out_word  | valid && ready
//  i_cfg_*  | in  | size regs   | i_cfg_we
//
// One item at a time: i_pix is ready only in the idle state. An item passes
// the check, column read, divide and output load states, with one line store
// read per window row for the new column. The first output of each row refills
// the whole window: 2*RADIUS+1 columns. Reset is synchronous; the line store
// needs no clearing pass. A word waiting on o_res holds the block in S_OUT.
`default_nettype none
`include "assert_macros.svh"
module box_blur_15x15_replicate #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF,
    parameter int RADIUS     = bblur_pkg::RADIUS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bblur_pkg::CFG_W-1:0]      i_cfg_data,
    bblur_if.sink                                 i_pix,
    bblur_if.source                               o_res
);
    localparam int PIX_W   = bblur_pkg::PIX_W;
    localparam int NUM_CH  = bblur_pkg::NUM_CH;
    localparam int CFG_W   = bblur_pkg::CFG_W;
    localparam int WIN     = 2 * RADIUS + 1;
    localparam int DIV_D   = WIN * WIN;
    localparam int RING_W  = $clog2(2 * RADIUS + 2);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = ($clog2(MAX_HEIGHT) > RING_W) ? $clog2(MAX_HEIGHT) : RING_W;
    localparam int WEW     = $clog2(MAX_WIDTH + 1);
    localparam int HEW     = $clog2(MAX_HEIGHT + 1);
    localparam int WXW     = (WEW > CFG_W) ? WEW : CFG_W;
    localparam int HXW     = (HEW > CFG_W) ? HEW : CFG_W;
    localparam int CXW     = $clog2(MAX_WIDTH + 2 * RADIUS);
    localparam int RXW     = $clog2(MAX_HEIGHT + 2 * RADIUS);
    localparam int AW      = RING_W + CW;
    localparam int DEPTH   = 1 << AW;
    localparam int KW      = $clog2(WIN + 1);
    localparam int CS_W    = $clog2((2 ** PIX_W - 1) * WIN + 1);
    localparam int SUM_W   = $clog2((2 ** PIX_W - 1) * DIV_D + 1);
    localparam int DIV_L   = $clog2(DIV_D);
    localparam int DIV_SH  = SUM_W + DIV_L;
    localparam int M_W     = SUM_W + 1;
    localparam int PROD_W  = SUM_W + M_W;
    localparam logic [M_W-1:0] DIV_M = M_W'(((64'd1 << DIV_SH) + DIV_D - 1) / DIV_D);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_COL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [CW-1:0]    r_in_col, r_out_col;
    logic [RW-1:0]    r_in_row, r_out_row;
    logic             r_in_complete;

    logic [KW-1:0]    r_k, r_left;
    logic             r_pend;
    logic [CXW-1:0]   r_cpos;

    logic [CS_W-1:0]   r_csum [NUM_CH];
    logic [SUM_W-1:0]  r_hsum [NUM_CH];
    logic [CS_W-1:0]   r_cs   [WIN][NUM_CH];
    logic [PROD_W-1:0] r_prod [NUM_CH];

    logic                 r_out_valid;
    bblur_pkg::t_out_word r_out_word;

    logic [WEW-1:0] eff_w, w_last;
    logic [HEW-1:0] eff_h, h_last;
    logic [WXW-1:0] w_x;
    logic [HXW-1:0] h_x;

    logic           acc_in, pix_store, rdy, issue, col_done, out_load, eof;
    logic [CXW-1:0] need_c, need_c_x, in_col_x, w_last_x, cc_x;
    logic [RXW-1:0] need_r, need_r_x, in_row_x, h_last_x, rp_x, rr_x;
    logic [AW-1:0]  waddr, raddr;
    logic [NUM_CH*PIX_W-1:0] rdata, wdata;

    // clamp the size registers to the legal range
    always_comb begin
        w_x = WXW'(r_cfg_w);
        h_x = HXW'(r_cfg_h);
        if (w_x == '0) begin
            eff_w = WEW'(1);
        end else if (w_x > WXW'(MAX_WIDTH)) begin
            eff_w = WEW'(MAX_WIDTH);
        end else begin
            eff_w = WEW'(w_x);
        end
        if (h_x == '0) begin
            eff_h = HEW'(1);
        end else if (h_x > HXW'(MAX_HEIGHT)) begin
            eff_h = HEW'(MAX_HEIGHT);
        end else begin
            eff_h = HEW'(h_x);
        end
        w_last = eff_w - WEW'(1);
        h_last = eff_h - HEW'(1);
    end

    // window readiness: input must lie past the bottom-right of the window
    always_comb begin
        w_last_x = CXW'(w_last);
        h_last_x = RXW'(h_last);
        in_col_x = CXW'(r_in_col);
        in_row_x = RXW'(r_in_row);
        need_c_x = CXW'(r_out_col) + CXW'(RADIUS);
        need_r_x = RXW'(r_out_row) + RXW'(RADIUS);
        need_c   = (need_c_x > w_last_x) ? w_last_x : need_c_x;
        need_r   = (need_r_x > h_last_x) ? h_last_x : need_r_x;
        rdy      = r_in_complete || (in_row_x > need_r) ||
                   ((in_row_x == need_r) && (in_col_x > need_c));
    end

    // line store addressing: row modulo the ring, clamped column
    always_comb begin
        rp_x = RXW'(r_out_row) + RXW'(r_k);
        if (rp_x < RXW'(RADIUS)) begin
            rr_x = '0;
        end else if (rp_x - RXW'(RADIUS) > h_last_x) begin
            rr_x = h_last_x;
        end else begin
            rr_x = rp_x - RXW'(RADIUS);
        end
        if (r_cpos < CXW'(RADIUS)) begin
            cc_x = '0;
        end else if (r_cpos - CXW'(RADIUS) > w_last_x) begin
            cc_x = w_last_x;
        end else begin
            cc_x = r_cpos - CXW'(RADIUS);
        end
        raddr = {rr_x[RING_W-1:0], cc_x[CW-1:0]};
        waddr = {r_in_row[RING_W-1:0], r_in_col};
        wdata = {i_pix.data.red, i_pix.data.green, i_pix.data.blue};
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign acc_in      = i_pix.valid && i_pix.ready;
    assign pix_store   = acc_in && (i_pix.data.kind == bblur_pkg::KIND_PIXEL) && !r_in_complete;
    assign issue       = (r_state == S_COL) && (r_k != KW'(WIN));
    assign col_done    = (r_state == S_COL) && (r_k == KW'(WIN)) && !r_pend;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || o_res.ready);
    assign eof         = (WEW'(r_out_col) == w_last) && (HEW'(r_out_row) == h_last);

    bblur_ram #(
        .WIDTH (NUM_CH * PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (pix_store),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = rdy ? S_COL : S_IDLE;
            end
            S_COL: begin
                if (col_done && (r_left == KW'(1))) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, size registers and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg_w       <= bblur_pkg::FRAME_SIZE_RST;
            r_cfg_h       <= bblur_pkg::FRAME_SIZE_RST;
            r_in_col      <= '0;
            r_in_row      <= '0;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_in_complete <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                // any write restarts the frame
                unique case (i_cfg_idx)
                    bblur_pkg::REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                    bblur_pkg::REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
                r_in_col      <= '0;
                r_in_row      <= '0;
                r_out_col     <= '0;
                r_out_row     <= '0;
                r_in_complete <= 1'b0;
            end else if (pix_store) begin
                // advance the input position
                if (WEW'(r_in_col) == w_last) begin
                    r_in_col <= '0;
                    if (HEW'(r_in_row) == h_last) begin
                        r_in_row      <= '0;
                        r_in_complete <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + RW'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end else if (out_load) begin
                // advance the output position, drop back to zero at frame end
                if (eof) begin
                    r_in_col      <= '0;
                    r_in_row      <= '0;
                    r_out_col     <= '0;
                    r_out_row     <= '0;
                    r_in_complete <= 1'b0;
                end else if (WEW'(r_out_col) == w_last) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // column read sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_left <= '0;
            r_pend <= 1'b0;
            r_cpos <= '0;
        end else if (r_state == S_CHK) begin
            r_k    <= '0;
            r_pend <= 1'b0;
            if (r_out_col == '0) begin
                r_cpos <= '0;
                r_left <= KW'(WIN);
            end else begin
                r_left <= KW'(1);
            end
        end else if (r_state == S_COL) begin
            r_pend <= issue;
            if (issue) begin
                r_k <= r_k + KW'(1);
            end
            if (col_done) begin
                r_k    <= '0;
                r_cpos <= r_cpos + CXW'(1);
                r_left <= r_left - KW'(1);
            end
        end
    end

    // column sums, window of column sums and running window sum
    always_ff @(posedge i_clk) begin
        if ((r_state == S_CHK) && (r_out_col == '0)) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_hsum[ch] <= '0;
                r_csum[ch] <= '0;
                for (int j = 0; j < WIN; j++) begin
                    r_cs[j][ch] <= '0;
                end
            end
        end else if (r_state == S_CHK) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_csum[ch] <= '0;
            end
        end else if (col_done) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_hsum[ch] <= r_hsum[ch] + SUM_W'(r_csum[ch]) - SUM_W'(r_cs[0][ch]);
                for (int j = 0; j < WIN - 1; j++) begin
                    r_cs[j][ch] <= r_cs[j+1][ch];
                end
                r_cs[WIN-1][ch] <= r_csum[ch];
                r_csum[ch]      <= '0;
            end
        end else if (r_pend) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_csum[ch] <= r_csum[ch] + CS_W'(rdata[ch*PIX_W +: PIX_W]);
            end
        end
    end

    // divide by the window area: multiply by the reciprocal
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_prod[ch] <= PROD_W'(r_hsum[ch]) * PROD_W'(DIV_M);
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.out_blue     <= r_prod[0][DIV_SH +: PIX_W];
            r_out_word.out_green    <= r_prod[1][DIV_SH +: PIX_W];
            r_out_word.out_red      <= r_prod[2][DIV_SH +: PIX_W];
            r_out_word.end_of_frame <= eof;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_word;

    `BB_ASSERT(a_complete_pos, i_clk, i_rst_n, r_in_complete |-> (r_in_row == '0 && r_in_col == '0), "input position not parked at frame completion")
    `BB_ASSERT(a_col_count, i_clk, i_rst_n, (r_state == S_COL) |-> (r_k <= KW'(WIN)), "column read counter overran")
    `BB_NEVER(a_out_ahead, i_clk, i_rst_n, !r_in_complete && (r_out_row > r_in_row), "output row ahead of input row")
endmodule
`default_nettype wire

// ===== verif/bblur_checker.sv =====
// Checker for the box blur: predicts every output word and compares it with the block.
`default_nettype none
module bblur_checker
    import bblur_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_pix_valid,
    input  wire logic                 i_pix_ready,
    input  wire t_in_word             i_pix_data,
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_ready,
    input  wire t_out_word            i_res_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_words_checked,
    output logic                      o_frame_in
);
    localparam int WIN       = 2 * RADIUS_DEF + 1;
    localparam int RING_SIZE = WIN * MAX_WIDTH_DEF + 4 * RADIUS_DEF + 4;

    logic [3*PIX_W-1:0] pix_ring [RING_SIZE];
    int unsigned        width_raw, height_raw;
    int unsigned        in_row, in_col, out_row, out_col;
    t_out_word          blurred_q [$];

    // Zero acts as one, oversize saturates
    function automatic int unsigned eff_size(int unsigned v, int unsigned vmax);
        if (v == 0) return 1;
        if (v > vmax) return vmax;
        return v;
    endfunction

    function automatic int clamp_coord(int v, int lim);
        if (v < 0) return 0;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    task automatic restart_frame();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        o_frame_in = 1'b0;
    endtask

    task automatic report(string what, int got, int want);
        if (o_fail_count < 20)
            $display("MISMATCH at word %0d: %s got %0d, want %0d",
                     o_words_checked, what, got, want);
        o_fail_count++;
    endtask

    // Store one word and work out the output pixel it lets out, if any
    task automatic absorb_word(t_in_word w);
        int unsigned fw, fh, need_r, need_c, sb, sg, sr;
        int          rr, cc;
        logic [23:0] p;
        t_out_word   ow;
        fw = eff_size(width_raw, MAX_WIDTH_DEF);
        fh = eff_size(height_raw, MAX_HEIGHT_DEF);
        if (t_kind'(w.kind) == KIND_PIXEL && !o_frame_in) begin
            pix_ring[(in_row * fw + in_col) % RING_SIZE] = {w.red, w.green, w.blue};
            in_col++;
            if (in_col >= fw) begin
                in_col = 0;
                in_row++;
                if (in_row >= fh) begin
                    in_row = 0;
                    o_frame_in = 1'b1;
                end
            end
        end
        need_r = out_row + RADIUS_DEF;
        need_c = out_col + RADIUS_DEF;
        if (need_r > fh - 1) need_r = fh - 1;
        if (need_c > fw - 1) need_c = fw - 1;
        if (!o_frame_in && in_row * fw + in_col <= need_r * fw + need_c) return;
        sb = 0;
        sg = 0;
        sr = 0;
        for (int dr = -RADIUS_DEF; dr <= RADIUS_DEF; dr++) begin
            rr = clamp_coord(int'(out_row) + dr, int'(fh));
            for (int dc = -RADIUS_DEF; dc <= RADIUS_DEF; dc++) begin
                cc = clamp_coord(int'(out_col) + dc, int'(fw));
                p = pix_ring[(rr * fw + cc) % RING_SIZE];
                sb += p[7:0];
                sg += p[15:8];
                sr += p[23:16];
            end
        end
        ow.out_blue     = PIX_W'(sb / (WIN * WIN));
        ow.out_green    = PIX_W'(sg / (WIN * WIN));
        ow.out_red      = PIX_W'(sr / (WIN * WIN));
        ow.end_of_frame = (out_row == fh - 1) && (out_col == fw - 1);
        blurred_q.push_back(ow);
        if (ow.end_of_frame) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= fw) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // Compare output words first, then apply writes and new input words
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            width_raw = FRAME_SIZE_RST;
            height_raw = FRAME_SIZE_RST;
            restart_frame();
            blurred_q.delete();
            o_fail_count = 0;
            o_words_checked = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (blurred_q.size() == 0) begin
                    report("word with nothing expected, blue", i_res_data.out_blue, 0);
                end else begin
                    want = blurred_q.pop_front();
                    if (i_res_data.out_blue !== want.out_blue)
                        report("out_blue", i_res_data.out_blue, want.out_blue);
                    if (i_res_data.out_green !== want.out_green)
                        report("out_green", i_res_data.out_green, want.out_green);
                    if (i_res_data.out_red !== want.out_red)
                        report("out_red", i_res_data.out_red, want.out_red);
                    if (i_res_data.end_of_frame !== want.end_of_frame)
                        report("end_of_frame", i_res_data.end_of_frame, want.end_of_frame);
                end
                o_words_checked++;
            end
            if (i_cfg_we) begin
                if (t_reg_idx'(i_cfg_idx) == REG_FRAME_WIDTH)
                    width_raw = i_cfg_data;
                else
                    height_raw = i_cfg_data;
                restart_frame();
            end
            if (i_pix_valid && i_pix_ready)
                absorb_word(i_pix_data);
        end
        o_pending = blurred_q.size();
    end
endmodule
`default_nettype wire

// ===== verif/box_blur_15x15_replicate_test.sv =====
// Testbench top: drives frames of random pixels into the box blur and gives the verdict.
`default_nettype none
module box_blur_15x15_replicate_test;
    import bblur_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    int                   fail_count, pending, words_checked;
    logic                 frame_in;
    int                   words_sent = 0;
    int                   frames_run = 0;
    int                   burst_left = 0;
    bit                   long_stall_done = 1'b0;

    bblur_if #(.T(t_in_word))  pix_ch ();
    bblur_if #(.T(t_out_word)) res_ch ();

    box_blur_15x15_replicate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    bblur_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pix_valid     (pix_ch.valid),
        .i_pix_ready     (pix_ch.ready),
        .i_pix_data      (pix_ch.data),
        .i_res_valid     (res_ch.valid),
        .i_res_ready     (res_ch.ready),
        .i_res_data      (res_ch.data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_frame_in      (frame_in)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Hard stop in case the block hangs
    initial begin
        #(12 * 3_000_000);
        $display("Verification failed");
        $finish;
    end

    // Receiver: one long hold-off, otherwise shifting stall patterns
    initial begin
        int mode;
        res_ch.ready = 1'b0;
        mode = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_stall_done && words_sent >= 600) begin
                res_ch.ready = 1'b0;
                repeat (600) @(negedge i_clk);
                long_stall_done = 1'b1;
            end
            if ($urandom_range(63) == 0) mode = $urandom_range(2);
            case (mode)
                0: res_ch.ready = 1'b1;
                1: res_ch.ready = ($urandom_range(3) != 0);
                default: res_ch.ready = ($urandom_range(3) == 0);
            endcase
        end
    end

    // Offer one word in bursts with random gaps; returns at a falling edge
    task automatic send_word(t_kind kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if (burst_left == 0) begin
            pix_ch.valid = 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        pix_ch.valid = 1'b1;
        pix_ch.data = '{kind: kind, blue: b, green: g, red: r};
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        pix_ch.valid = 1'b0;
        burst_left--;
        words_sent++;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_pixel();
        send_word(KIND_PIXEL, pick_channel(), pick_channel(), pick_channel());
    endtask

    // Wait until every word has arrived and the block has gone quiet
    task automatic wait_idle();
        pix_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Feed n pixels of a frame; when the frame is whole, drain it to its end
    task automatic run_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int n);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        frames_run++;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0) send_word(KIND_DRAIN, 8'($urandom), 8'($urandom),
                                                  8'($urandom));
            send_pixel();
        end
        // pixels offered here are dropped by the block but still let words out
        while (frame_in) begin
            if ($urandom_range(3) == 0) send_pixel();
            else send_word(KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    function automatic int eff_w(int v);
        return (v == 0) ? 1 : v;
    endfunction

    initial begin
        int w, h, n;
        pix_ch.valid = 1'b0;
        pix_ch.data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: drain with nothing ready, one pixel at reset size, then restart
        send_word(KIND_DRAIN, 8'hff, 8'hff, 8'hff);
        send_word(KIND_PIXEL, 8'hff, 8'h00, 8'hff);
        run_frame(11'd0, 11'd0, 1);
        run_frame(11'd3, 11'd2, 6);
        run_frame(11'd16, 11'd1, 16);

        // Random: mostly small frames, some cut short by a register write
        while (words_sent < 600) begin
            w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
            n = eff_w(w) * eff_w(h);
            if ($urandom_range(9) == 0) n = $urandom_range(n);
            run_frame(11'(w), 11'(h), n);
        end

        // Extremes: full widest row, tallest and largest frames cut short
        run_frame(11'd2047, 11'd1, 1024);
        run_frame(11'd1, 11'd2047, 40);
        run_frame(11'd1024, 11'd1024, 60);

        while (words_sent < 1950) begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 16);
            n = w * h;
            if ($urandom_range(9) == 0) n = $urandom_range(n);
            run_frame(11'(w), 11'(h), n);
        end

        pix_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        $display("Ran %0d frames: %0d input words sent, %0d output words checked",
                 frames_run, words_sent, words_checked);
        $display("Sizes covered zero, saturating, single pixel and widest row framings");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
